// ----- rtl/pds_pkg.sv -----
// Shared types, constants and helpers for the percent decode stream block.
package pds_pkg;

  localparam logic [7:0] PCT_CHAR = 8'h25;
  localparam logic [7:0] MIN_VALID_RESET = 8'd32;

  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_DONE  = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    PH_VALUE       = 2'd0,
    PH_AFTER_PCT   = 2'd1,
    PH_AFTER_DIGIT = 2'd2,
    PH_ERROR       = 2'd3
  } phase_t;

  // One input item's worth of results: up to three, all of the same kind.
  typedef struct packed {
    logic [1:0] cnt;
    logic [1:0] kind;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
  } bundle_t;

  // {is_hex, nibble}
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end
    return r;
  endfunction

endpackage

// ----- rtl/pds_front.sv -----
// Front end: accepts encoded bytes, tracks escape state, builds result bundles.
module pds_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic [7:0]          cfg_wr_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          data_byte,
  input  logic                end_marker,
  input  logic                q_full,
  output logic                q_push,
  output pds_pkg::bundle_t    q_data
);

  pds_pkg::phase_t phase;
  pds_pkg::phase_t phase_next;
  logic [7:0]      min_valid_char;
  logic [3:0]      high_nibble;
  logic [3:0]      high_nibble_next;
  logic [7:0]      first_digit_char;
  logic [7:0]      first_digit_char_next;

  logic            accept;
  logic [4:0]      hx;
  logic            is_hex;
  logic            invalid;
  logic            is_pct;
  pds_pkg::bundle_t bnd;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign hx       = pds_pkg::hex_val(data_byte);
  assign is_hex   = hx[4];
  // anything with the top bit set counts as negative and is always invalid
  assign invalid  = data_byte[7] || (data_byte < min_valid_char);
  assign is_pct   = (data_byte == pds_pkg::PCT_CHAR);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= pds_pkg::PH_VALUE;
      min_valid_char <= pds_pkg::MIN_VALID_RESET;
    end else begin
      if (cfg_wr_en) begin
        min_valid_char <= cfg_wr_data;
      end
      if (accept) begin
        phase <= phase_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      high_nibble      <= high_nibble_next;
      first_digit_char <= first_digit_char_next;
    end
  end

  // next state
  always_comb begin
    phase_next            = phase;
    high_nibble_next      = high_nibble;
    first_digit_char_next = first_digit_char;
    if (end_marker) begin
      phase_next = (phase == pds_pkg::PH_ERROR) ? pds_pkg::PH_ERROR : pds_pkg::PH_VALUE;
    end else if (phase != pds_pkg::PH_ERROR) begin
      if (invalid) begin
        phase_next = pds_pkg::PH_ERROR;
      end else begin
        case (phase)
          pds_pkg::PH_VALUE: begin
            if (is_pct) phase_next = pds_pkg::PH_AFTER_PCT;
          end
          pds_pkg::PH_AFTER_PCT: begin
            if (is_hex) begin
              phase_next            = pds_pkg::PH_AFTER_DIGIT;
              high_nibble_next      = hx[3:0];
              first_digit_char_next = data_byte;
            end else if (!is_pct) begin
              phase_next = pds_pkg::PH_VALUE;
            end
          end
          pds_pkg::PH_AFTER_DIGIT: begin
            if (is_hex || !is_pct) phase_next = pds_pkg::PH_VALUE;
            else phase_next = pds_pkg::PH_AFTER_PCT;
          end
          default: phase_next = phase;
        endcase
      end
    end
  end

  // outputs: result bundle for this item
  always_comb begin
    bnd      = '0;
    bnd.kind = pds_pkg::KIND_DATA;
    if (end_marker) begin
      bnd.cnt  = 2'd1;
      bnd.kind = pds_pkg::KIND_DONE;
    end else if (phase != pds_pkg::PH_ERROR) begin
      if (invalid) begin
        bnd.cnt  = 2'd1;
        bnd.kind = pds_pkg::KIND_ERROR;
      end else begin
        case (phase)
          pds_pkg::PH_VALUE: begin
            if (!is_pct) begin
              bnd.cnt = 2'd1;
              bnd.b0  = data_byte;
            end
          end
          pds_pkg::PH_AFTER_PCT: begin
            if (!is_hex) begin
              bnd.b0  = pds_pkg::PCT_CHAR;
              bnd.b1  = data_byte;
              bnd.cnt = is_pct ? 2'd1 : 2'd2;
            end
          end
          pds_pkg::PH_AFTER_DIGIT: begin
            if (is_hex) begin
              bnd.cnt = 2'd1;
              bnd.b0  = {high_nibble, hx[3:0]};
            end else begin
              bnd.b0  = pds_pkg::PCT_CHAR;
              bnd.b1  = first_digit_char;
              bnd.b2  = data_byte;
              bnd.cnt = is_pct ? 2'd2 : 2'd3;
            end
          end
          default: bnd.cnt = 2'd0;
        endcase
      end
    end
  end

  assign q_push = accept && (bnd.cnt != 2'd0);
  assign q_data = bnd;

endmodule

// ----- rtl/pds_queue.sv -----
// Small bundle queue between the front end and the output serializer.
module pds_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  pds_pkg::bundle_t push_data,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output pds_pkg::bundle_t head
);

  pds_pkg::bundle_t                  slots [pds_pkg::QUEUE_DEPTH];
  logic [pds_pkg::QUEUE_AW-1:0]      wr_ptr;
  logic [pds_pkg::QUEUE_AW-1:0]      rd_ptr;
  logic [pds_pkg::QUEUE_AW:0]        count;
  logic                              do_push;
  logic                              do_pop;

  assign full    = (count == (pds_pkg::QUEUE_AW+1)'(pds_pkg::QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_data;
  end

endmodule

// ----- rtl/pds_back.sv -----
// Back end: serializes queued bundles into single results behind an output register.
module pds_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_empty,
  input  pds_pkg::bundle_t q_head,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_byte,
  output logic [1:0]       kind,
  output logic             last
);

  logic [1:0] idx;
  logic       load;
  logic       is_last;
  logic [7:0] sel_byte;

  assign load    = !q_empty && (!out_valid || out_ready);
  assign is_last = (idx == (q_head.cnt - 2'd1));
  assign q_pop   = load && is_last;

  always_comb begin
    case (idx)
      2'd0:    sel_byte = q_head.b0;
      2'd1:    sel_byte = q_head.b1;
      default: sel_byte = q_head.b2;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 2'd0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= is_last ? 2'd0 : idx + 2'd1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte <= sel_byte;
      kind     <= q_head.kind;
      last     <= is_last;
    end
  end

endmodule

// ----- rtl/percent_decode_stream_unit.sv -----
// Streaming URL percent-decoder: top level.
//
// Input stream (s_axis): one encoded byte per transaction in tdata; tlast set
// marks an end-of-value item whose tdata is ignored.
// Output stream (m_axis): one decoded result per transaction. tuser carries
// the kind (data byte, value done, error entered); tdata is the byte for data
// results and zero otherwise; tlast marks the final result of an input item.
// Configuration: cfg_wr_en writes cfg_wr_data into the minimum valid character
// register (reset value 32); write only while the stream is idle.
// Path: results of accepted items go as bundles into a four-entry queue, then one
// result at a time into the output register. Throughput: one input per cycle;
// the output side moves one result per cycle while the receiver is ready, so an
// item with three results (a broken escape) holds the output longer while
// the queue keeps the input running. Input stalls only when that queue is full.
// Reset: decoder returns to the plain value phase, queue and output empty.
// A stalled receiver holds the current result stable; the queue then fills
// and tready drops.
module percent_decode_stream_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
  input  logic       s_axis_tlast,   // end_marker
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic [1:0] m_axis_tuser,   // [1:0] kind
  output logic       m_axis_tlast    // last
);

  logic             q_push;
  logic             q_full;
  logic             q_pop;
  logic             q_empty;
  pds_pkg::bundle_t q_in;
  pds_pkg::bundle_t q_head;

  pds_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .data_byte   (s_axis_tdata),
    .end_marker  (s_axis_tlast),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_data      (q_in)
  );

  pds_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  pds_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_byte  (m_axis_tdata),
    .kind      (m_axis_tuser),
    .last      (m_axis_tlast)
  );

endmodule

// ----- sim/tb_top.sv -----
// Self-checking testbench for percent_decode_stream_unit: random stream traffic with a decoder model.
`timescale 1ns / 100ps

module tb_top;
  import pds_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       fin;
  } enc_t;

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] kind;
    logic       last;
  } dec_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_wr_en = 1'b0;
  logic [7:0] cfg_wr_data = 8'd0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'd0;
  logic       s_axis_tlast = 1'b0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;
  logic       m_axis_tlast;

  percent_decode_stream_unit dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // encoded bytes waiting to go out, decoded results still owed by the block
  enc_t enc_q[$];
  dec_t decoded_q[$];

  // decoder model state
  phase_t     dec_phase = PH_VALUE;
  logic [3:0] hi_nib = 4'd0;
  logic [7:0] first_digit = 8'd0;
  logic [7:0] min_char = MIN_VALID_RESET;

  int fail_cnt = 0;
  int n_sent = 0;
  int src_gap = 0;
  int snk_gap = 0;
  int src_idle_pct = 10;
  int snk_idle_pct = 10;
  bit quiet = 1'b0;

  function automatic int hex_nibble(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return c - 8'h30;       // 0-9
    if (c >= 8'h61 && c <= 8'h66) return c - 8'h61 + 10;  // a-f
    if (c >= 8'h41 && c <= 8'h46) return c - 8'h41 + 10;  // A-F
    return -1;
  endfunction

  task automatic decode_item(input logic [7:0] c, input logic fin);
    dec_t res[$];
    int nib;
    nib = hex_nibble(c);
    if (fin) begin
      res.push_back({8'h00, KIND_DONE, 1'b0});
      if (dec_phase != PH_ERROR) dec_phase = PH_VALUE;
      hi_nib = 4'd0;
      first_digit = 8'd0;
    end else if (dec_phase != PH_ERROR) begin
      // bytes from 0x80 up count as negative, so they always fail the check
      if (c[7] || c < min_char) begin
        res.push_back({8'h00, KIND_ERROR, 1'b0});
        dec_phase = PH_ERROR;
      end else begin
        case (dec_phase)
          PH_AFTER_PCT: begin
            if (nib >= 0) begin
              hi_nib = nib[3:0];
              first_digit = c;
              dec_phase = PH_AFTER_DIGIT;
            end else begin
              res.push_back({PCT_CHAR, KIND_DATA, 1'b0});
              if (c != PCT_CHAR) begin
                res.push_back({c, KIND_DATA, 1'b0});
                dec_phase = PH_VALUE;
              end
            end
          end
          PH_AFTER_DIGIT: begin
            if (nib >= 0) begin
              res.push_back({{hi_nib, nib[3:0]}, KIND_DATA, 1'b0});
              dec_phase = PH_VALUE;
            end else begin
              res.push_back({PCT_CHAR, KIND_DATA, 1'b0});
              res.push_back({first_digit, KIND_DATA, 1'b0});
              // broken escape: current byte is reparsed as plain input
              if (c == PCT_CHAR) begin
                dec_phase = PH_AFTER_PCT;
              end else begin
                res.push_back({c, KIND_DATA, 1'b0});
                dec_phase = PH_VALUE;
              end
            end
          end
          default: begin
            if (c == PCT_CHAR) dec_phase = PH_AFTER_PCT;
            else res.push_back({c, KIND_DATA, 1'b0});
          end
        endcase
      end
    end
    if (res.size() > 0) res[res.size() - 1].last = 1'b1;
    foreach (res[i]) decoded_q.push_back(res[i]);
  endtask

  task automatic report(input string field, input int want, input int got);
    fail_cnt++;
    $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
  endtask

  // input driver
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      src_gap = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) decode_item(s_axis_tdata, s_axis_tlast);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_gap == 0 && !quiet && $urandom_range(0, 99) < src_idle_pct)
          src_gap = $urandom_range(1, 18);
        if (src_gap > 0) begin
          src_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (enc_q.size() > 0) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= enc_q[0].data;
          s_axis_tlast <= enc_q[0].fin;
          void'(enc_q.pop_front());
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // output monitor and checker
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      snk_gap = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (decoded_q.size() == 0) begin
          fail_cnt++;
          $display("%0t: unexpected result: expected none, actual data %02h kind %0d last %0b",
                   $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
        end else begin
          if (m_axis_tdata !== decoded_q[0].data)
            report("out_byte", decoded_q[0].data, m_axis_tdata);
          if (m_axis_tuser !== decoded_q[0].kind)
            report("kind", decoded_q[0].kind, m_axis_tuser);
          if (m_axis_tlast !== decoded_q[0].last)
            report("last", decoded_q[0].last, m_axis_tlast);
          void'(decoded_q.pop_front());
        end
      end
      if (snk_gap == 0 && !quiet && $urandom_range(0, 99) < snk_idle_pct)
        snk_gap = $urandom_range(1, 18);
      if (snk_gap > 0) begin
        snk_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic send(input logic [7:0] d, input logic fin);
    enc_q.push_back({d, fin});
    n_sent++;
  endtask

  function automatic logic [7:0] pick_plain(input int lo);
    logic [7:0] c;
    do c = 8'($urandom_range(lo, 127)); while (c == PCT_CHAR);
    return c;
  endfunction

  function automatic logic [7:0] pick_nonhex(input int lo);
    logic [7:0] c;
    do c = pick_plain(lo); while (hex_nibble(c) >= 0);
    return c;
  endfunction

  function automatic logic [7:0] pick_hex();
    int r;
    r = $urandom_range(0, 21);
    if (r < 10) return 8'(8'h30 + r);
    if (r < 16) return 8'(8'h61 + r - 10);
    return 8'(8'h41 + r - 16);
  endfunction

  // waits until the block has nothing in flight, including result-free items
  task automatic wait_drained();
    do @(negedge clk); while (enc_q.size() != 0 || s_axis_tvalid || decoded_q.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_min_char(input logic [7:0] v);
    wait_drained();
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    min_char = v;
  endtask

  // plain bytes, well-formed and broken escapes, ends of value; lo must leave '%' valid
  task automatic send_mixed(input int n, input int lo);
    int start;
    start = n_sent;
    while (n_sent - start < n) begin
      case ($urandom_range(0, 11))
        0, 1, 2: send(pick_plain(lo), 1'b0);
        3, 4, 5, 6: begin
          send(PCT_CHAR, 1'b0);
          send(pick_hex(), 1'b0);
          send(pick_hex(), 1'b0);
        end
        7: begin
          send(PCT_CHAR, 1'b0);
          send(PCT_CHAR, 1'b0);
        end
        8: begin
          send(PCT_CHAR, 1'b0);
          send(pick_nonhex(lo), 1'b0);
        end
        9: begin
          send(PCT_CHAR, 1'b0);
          send(pick_hex(), 1'b0);
          send($urandom_range(0, 3) == 0 ? PCT_CHAR : pick_nonhex(lo), 1'b0);
        end
        10: send(8'($urandom_range(0, 255)), 1'b1);
        default: begin
          // truncated escape closed by end of value
          send(PCT_CHAR, 1'b0);
          if ($urandom_range(0, 1)) send(pick_hex(), 1'b0);
          send(8'($urandom_range(0, 255)), 1'b1);
        end
      endcase
    end
  endtask

  task automatic set_idle();
    src_idle_pct = $urandom_range(0, 25);
    snk_idle_pct = $urandom_range(0, 25);
  endtask

  initial begin : stimulus
    string dir;
    int n;
    dir = "%41%fF%%7e%z%4g%4%41";
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: threshold edges, escapes of both cases, broken and truncated escapes
    send(8'h20, 1'b0);
    send(8'h7f, 1'b0);
    for (int i = 0; i < dir.len(); i++) send(dir[i], 1'b0);
    send(PCT_CHAR, 1'b0);
    send(8'h00, 1'b1);
    send(PCT_CHAR, 1'b0);
    send(8'h61, 1'b0);
    send(8'hff, 1'b1);

    set_min_char(8'd0);
    set_idle();
    send_mixed(120, 0);

    n = $urandom_range(0, 37);
    set_min_char(8'(n));
    set_idle();
    send_mixed(120, n);

    // threshold above '%': plain traffic and ends only
    n = $urandom_range(38, 127);
    set_min_char(8'(n));
    set_idle();
    n_sent = 0;
    while (n_sent < 60) begin
      if ($urandom_range(0, 7) == 0) send(8'($urandom_range(0, 255)), 1'b1);
      else send(pick_plain(n), 1'b0);
    end

    n = $urandom_range(0, 37);
    set_min_char(8'(n));
    quiet = 1'b1;
    send_mixed(80, n);

    // enter the sticky error state, sometimes in the middle of an escape
    case ($urandom_range(0, 2))
      1: send(PCT_CHAR, 1'b0);
      2: begin
        send(PCT_CHAR, 1'b0);
        send(pick_hex(), 1'b0);
      end
      default: ;
    endcase
    set_min_char(8'h80);
    send(8'($urandom_range(0, 255)), 1'b0);
    repeat (24) send(8'($urandom_range(0, 255)), $urandom_range(0, 2) == 0);

    wait_drained();
    repeat (20) @(negedge clk);
    if (fail_cnt == 0 && decoded_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("Verification failed");
    $finish;
  end

endmodule
